@@ src/radio_synced_calendar_clock_top_assert.svh @@
// Assertion macros shared by the calendar clock RTL.
`ifndef RADIO_SYNCED_CALENDAR_CLOCK_TOP_ASSERT_SVH
`define RADIO_SYNCED_CALENDAR_CLOCK_TOP_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define RSCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar clock assertion failed");

// Check a consequent in the cycle after its antecedent.
`define RSCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("calendar clock assertion failed");

`endif

@@ src/rscc_pkg.sv @@
// Types, constants and calendar helper functions for the calendar clock.
`timescale 1ns / 1ps

package rscc_pkg;

  // Field widths
  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned WEEKDAY_W = 3;
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MINUTE_W  = 6;
  localparam int unsigned SECOND_W  = 6;
  localparam int unsigned DRIFT_W   = 16;
  localparam int unsigned LEVEL_W   = 3;

  // Parameter defaults
  localparam int unsigned CRYSTAL_HZ_DEFAULT    = 32768;
  localparam int unsigned TOLERANCE_PPM_DEFAULT = 20;
  localparam int unsigned MICROS_PER_SECOND     = 1000000;

  // Function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SYNC = 1'b1;

  // Drift levels
  localparam logic [LEVEL_W-1:0] DRIFT_LVL_FINE  = 3'd0;
  localparam logic [LEVEL_W-1:0] DRIFT_LVL_10MS  = 3'd1;
  localparam logic [LEVEL_W-1:0] DRIFT_LVL_50MS  = 3'd2;
  localparam logic [LEVEL_W-1:0] DRIFT_LVL_100MS = 3'd3;
  localparam logic [LEVEL_W-1:0] DRIFT_LVL_1S    = 3'd4;

  // Calendar limits; all but MINUTE_LEN_STD and DRIFT_MAX are one bit wider than the counters they compare against
  localparam logic [SECOND_W-1:0] MINUTE_LEN_STD   = 6'd60;
  localparam logic [MINUTE_W:0]   MINUTES_PER_HOUR = 7'd60;
  localparam logic [HOUR_W:0]     HOURS_PER_DAY    = 6'd24;
  localparam logic [MONTH_W:0]    MONTHS_PER_YEAR  = 5'd12;
  localparam logic [WEEKDAY_W:0]  DAYS_PER_WEEK    = 4'd7;
  localparam logic [DRIFT_W-1:0]  DRIFT_MAX        = 16'hFFFF;

  // Reset date
  localparam logic [YEAR_W-1:0] YEAR_RESET = 14'd2000;

  // Month codes
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd5;
  localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd7;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd8;
  localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;

  // Reciprocal of 100 for 14-bit years: ceil(2^19 / 100)
  localparam int unsigned      DIV100_SHIFT = 19;
  localparam logic [12:0]      DIV100_MUL   = 13'd5243;

  // One input transaction as held in the input register
  typedef struct packed {
    logic                  func;
    logic [YEAR_W-1:0]     year;
    logic [MONTH_W-1:0]    month;
    logic [DAY_W-1:0]      day;
    logic [WEEKDAY_W-1:0]  weekday;
    logic [HOUR_W-1:0]     hour;
    logic [MINUTE_W-1:0]   minute;
    logic [SECOND_W-1:0]   second;
    logic [SECOND_W-1:0]   minute_length;
    logic                  summer_time;
  } sync_t;

  // Gregorian leap rule; divisibility by 100 from the low product bits
  function automatic logic leap_of(input logic [YEAR_W-1:0] y);
    logic [26:0] prod;
    logic [7:0]  quot;
    logic        div100;
    prod   = 27'(y) * 27'(DIV100_MUL);
    quot   = prod[26:DIV100_SHIFT];
    div100 = (prod[DIV100_SHIFT-1:0] < 19'(DIV100_MUL));
    if (div100) begin
      return (quot[1:0] == 2'b00);
    end
    return (y[1:0] == 2'b00);
  endfunction

  // Days in a month; codes past December read as 31
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
      MONTH_AUG, MONTH_OCT, MONTH_DEC: len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ src/radio_synced_calendar_clock_top.sv @@
// Calendar clock top level: input register, single-pass update, result register.
`timescale 1ns / 1ps

// Calendar clock fed with half-second ticks and sync transactions. One transaction is
// accepted per clock, back to back, while the output is not stalled; its result
// passes the input register and the combinational calendar update into the result
// register. A stalled output holds the result while one further transaction
// waits in the input register. Every second tick advances the second; carries run
// through minute, hour, day, month and year with the Gregorian leap rule. A sync
// transaction loads time and date and clears the half phase and drift estimate. The
// drift estimate grows by TOLERANCE_PPM every 1000000/(CRYSTAL_HZ/2) ticks (61 at the
// default crystal), saturates at 0xffff and is graded against CRYSTAL_HZ/100, /20,
// /10 and /1. Reset date is 2000-01-01 00:00:00 with weekday code 0.
module radio_synced_calendar_clock_top
  import rscc_pkg::*;
#(
  parameter int unsigned CRYSTAL_HZ    = CRYSTAL_HZ_DEFAULT,
  parameter int unsigned TOLERANCE_PPM = TOLERANCE_PPM_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [YEAR_W-1:0]    sync_year_i,
  input  logic [MONTH_W-1:0]   sync_month_i,
  input  logic [DAY_W-1:0]     sync_day_i,
  input  logic [WEEKDAY_W-1:0] sync_weekday_i,
  input  logic [HOUR_W-1:0]    sync_hour_i,
  input  logic [MINUTE_W-1:0]  sync_minute_i,
  input  logic [SECOND_W-1:0]  sync_second_i,
  input  logic [SECOND_W-1:0]  sync_minute_length_i,
  input  logic                 sync_summer_time_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [HOUR_W-1:0]    hour_o,
  output logic [MINUTE_W-1:0]  minute_o,
  output logic [SECOND_W-1:0]  second_o,
  output logic [DAY_W-1:0]     day_o,
  output logic [MONTH_W-1:0]   month_o,
  output logic [YEAR_W-1:0]    year_o,
  output logic [WEEKDAY_W-1:0] weekday_o,
  output logic                 summer_time_o,
  output logic [LEVEL_W-1:0]   drift_level_o,
  output logic                 minute_marker_o,
  output logic                 second_phase_o
);

`include "radio_synced_calendar_clock_top_assert.svh"

  localparam int unsigned DRIFT_PERIOD = MICROS_PER_SECOND / (CRYSTAL_HZ / 2);
  localparam int unsigned TICK_W       = $clog2(DRIFT_PERIOD);
  localparam logic [TICK_W:0]    PERIOD_LIM = (TICK_W + 1)'(DRIFT_PERIOD);
  localparam logic [DRIFT_W:0]   TOL_INC    = (DRIFT_W + 1)'(TOLERANCE_PPM);
  localparam logic [DRIFT_W:0]   THR_1S     = (DRIFT_W + 1)'(CRYSTAL_HZ);
  localparam logic [DRIFT_W:0]   THR_100MS  = (DRIFT_W + 1)'(CRYSTAL_HZ / 10);
  localparam logic [DRIFT_W:0]   THR_50MS   = (DRIFT_W + 1)'(CRYSTAL_HZ / 20);
  localparam logic [DRIFT_W:0]   THR_10MS   = (DRIFT_W + 1)'(CRYSTAL_HZ / 100);

  // Handshake and pipeline control
  logic  in_valid_q, in_valid_d;
  logic  out_valid_q, out_valid_d;
  logic  advance, fire;
  sync_t in_q;

  // Calendar state
  logic [HOUR_W-1:0]    hour_q, hour_d;
  logic [MINUTE_W-1:0]  minute_q, minute_d;
  logic [SECOND_W-1:0]  second_q, second_d;
  logic [DAY_W-1:0]     day_q, day_d;
  logic [MONTH_W-1:0]   month_q, month_d;
  logic [YEAR_W-1:0]    year_q, year_d;
  logic [WEEKDAY_W-1:0] weekday_q, weekday_d;
  logic                 dst_q, dst_d;
  logic                 leap_q, leap_d;
  logic [DAY_W-1:0]     month_len_q, month_len_d;
  logic [SECOND_W-1:0]  minute_len_q, minute_len_d;
  logic                 half_phase_q, half_phase_d;
  logic [TICK_W-1:0]    tick_cnt_q, tick_cnt_d;
  logic [DRIFT_W-1:0]   drift_q, drift_d;
  logic                 marker_q, marker_d;
  logic                 phase_q, phase_d;

  // Incremented values, one bit wider for the carry compare
  logic [SECOND_W:0]    second_inc;
  logic [MINUTE_W:0]    minute_inc;
  logic [HOUR_W:0]      hour_inc;
  logic [DAY_W:0]       day_inc;
  logic [MONTH_W:0]     month_inc;
  logic [WEEKDAY_W:0]   weekday_inc;
  logic [TICK_W:0]      tick_inc;
  logic [DRIFT_W:0]     drift_sum;
  logic [DRIFT_W:0]     drift_ext;

  // Move a transaction on when the result slot is free or being emptied
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= '{func:          func_i,
                year:          sync_year_i,
                month:         sync_month_i,
                day:           sync_day_i,
                weekday:       sync_weekday_i,
                hour:          sync_hour_i,
                minute:        sync_minute_i,
                second:        sync_second_i,
                minute_length: sync_minute_length_i,
                summer_time:   sync_summer_time_i};
    end
  end

  assign second_inc  = {1'b0, second_q} + 1'b1;
  assign minute_inc  = {1'b0, minute_q} + 1'b1;
  assign hour_inc    = {1'b0, hour_q} + 1'b1;
  assign day_inc     = {1'b0, day_q} + 1'b1;
  assign month_inc   = {1'b0, month_q} + 1'b1;
  assign weekday_inc = {1'b0, weekday_q} + 1'b1;
  assign tick_inc    = {1'b0, tick_cnt_q} + 1'b1;
  assign drift_sum   = {1'b0, drift_q} + TOL_INC;

  // Calendar update: sync load or one tick with the carry chain
  always_comb begin
    hour_d       = hour_q;
    minute_d     = minute_q;
    second_d     = second_q;
    day_d        = day_q;
    month_d      = month_q;
    year_d       = year_q;
    weekday_d    = weekday_q;
    dst_d        = dst_q;
    leap_d       = leap_q;
    month_len_d  = month_len_q;
    minute_len_d = minute_len_q;
    half_phase_d = half_phase_q;
    tick_cnt_d   = tick_cnt_q;
    drift_d      = drift_q;
    marker_d     = marker_q;
    phase_d      = phase_q;
    if (fire) begin
      marker_d = 1'b0;
      phase_d  = 1'b0;
      if (in_q.func == FUNC_SYNC) begin
        year_d       = in_q.year;
        month_d      = in_q.month;
        day_d        = in_q.day;
        weekday_d    = in_q.weekday;
        hour_d       = in_q.hour;
        minute_d     = in_q.minute;
        second_d     = in_q.second;
        minute_len_d = in_q.minute_length;
        dst_d        = in_q.summer_time;
        leap_d       = leap_of(in_q.year);
        month_len_d  = month_len(in_q.month, leap_d);
        half_phase_d = 1'b0;
        tick_cnt_d   = '0;
        drift_d      = '0;
      end else begin
        // Grow the drift estimate once per drift period, saturating
        if (tick_inc >= PERIOD_LIM) begin
          tick_cnt_d = '0;
          drift_d    = drift_sum[DRIFT_W] ? DRIFT_MAX : drift_sum[DRIFT_W-1:0];
        end else begin
          tick_cnt_d = tick_inc[TICK_W-1:0];
        end
        if (half_phase_q) begin
          half_phase_d = 1'b0;
        end else begin
          half_phase_d = 1'b1;
          phase_d      = 1'b1;
          if (second_inc >= {1'b0, minute_len_q}) begin
            second_d     = '0;
            minute_len_d = MINUTE_LEN_STD;
            marker_d     = 1'b1;
            if (minute_inc >= MINUTES_PER_HOUR) begin
              minute_d = '0;
              if (hour_inc >= HOURS_PER_DAY) begin
                hour_d = '0;
                if (day_inc >= {1'b0, month_len_q}) begin
                  day_d = '0;
                  if (month_inc >= MONTHS_PER_YEAR) begin
                    month_d = '0;
                    year_d  = year_q + 1'b1;
                    leap_d  = leap_of(year_d);
                  end else begin
                    month_d = month_inc[MONTH_W-1:0];
                  end
                  month_len_d = month_len(month_d, leap_d);
                end else begin
                  day_d = day_inc[DAY_W-1:0];
                end
                weekday_d = (weekday_inc >= DAYS_PER_WEEK) ? '0
                                                           : weekday_inc[WEEKDAY_W-1:0];
              end else begin
                hour_d = hour_inc[HOUR_W-1:0];
              end
            end else begin
              minute_d = minute_inc[MINUTE_W-1:0];
            end
          end else begin
            second_d = second_inc[SECOND_W-1:0];
          end
        end
      end
    end
  end

  // Control and calendar registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      hour_q       <= '0;
      minute_q     <= '0;
      second_q     <= '0;
      day_q        <= '0;
      month_q      <= MONTH_JAN;
      year_q       <= YEAR_RESET;
      weekday_q    <= '0;
      dst_q        <= 1'b0;
      leap_q       <= 1'b1;
      month_len_q  <= month_len(MONTH_JAN, 1'b1);
      minute_len_q <= MINUTE_LEN_STD;
      half_phase_q <= 1'b0;
      tick_cnt_q   <= '0;
      drift_q      <= '0;
      marker_q     <= 1'b0;
      phase_q      <= 1'b0;
    end else begin
      in_valid_q   <= in_valid_d;
      out_valid_q  <= out_valid_d;
      hour_q       <= hour_d;
      minute_q     <= minute_d;
      second_q     <= second_d;
      day_q        <= day_d;
      month_q      <= month_d;
      year_q       <= year_d;
      weekday_q    <= weekday_d;
      dst_q        <= dst_d;
      leap_q       <= leap_d;
      month_len_q  <= month_len_d;
      minute_len_q <= minute_len_d;
      half_phase_q <= half_phase_d;
      tick_cnt_q   <= tick_cnt_d;
      drift_q      <= drift_d;
      marker_q     <= marker_d;
      phase_q      <= phase_d;
    end
  end

  // Grade the drift estimate
  assign drift_ext = {1'b0, drift_q};
  always_comb begin
    priority if (drift_ext >= THR_1S) begin
      drift_level_o = DRIFT_LVL_1S;
    end else if (drift_ext >= THR_100MS) begin
      drift_level_o = DRIFT_LVL_100MS;
    end else if (drift_ext >= THR_50MS) begin
      drift_level_o = DRIFT_LVL_50MS;
    end else if (drift_ext >= THR_10MS) begin
      drift_level_o = DRIFT_LVL_10MS;
    end else begin
      drift_level_o = DRIFT_LVL_FINE;
    end
  end

  // State only changes when a result is loaded, so it is the result
  assign out_valid_o     = out_valid_q;
  assign hour_o          = hour_q;
  assign minute_o        = minute_q;
  assign second_o        = second_q;
  assign day_o           = day_q;
  assign month_o         = month_q;
  assign year_o          = year_q;
  assign weekday_o       = weekday_q;
  assign summer_time_o   = dst_q;
  assign minute_marker_o = marker_q;
  assign second_phase_o  = phase_q;

  `RSCC_ASSERT_NOW(a_marker_at_zero, out_valid_o && minute_marker_o,
                   second_phase_o && (second_o == '0))
  `RSCC_ASSERT_NOW(a_stall_means_full, !in_ready_o, in_valid_q && out_valid_q)
  `RSCC_ASSERT_NEXT(a_phase_toggles, fire && (in_q.func == FUNC_TICK),
                    half_phase_q != $past(half_phase_q))
  `RSCC_ASSERT_NOW(a_drift_grows, fire && (in_q.func == FUNC_TICK), drift_d >= drift_q)

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the half-second-tick calendar clock.
`timescale 1ns / 1ps

module tb_top;
  import rscc_pkg::*;

  // Run shape
  localparam int IDLE_PCT        = 19;
  localparam int RANDOM_ITEMS    = 720;
  localparam int DRIFT_RUN_TICKS = 360;
  localparam int CALM_TICKS      = 240;
  localparam int HOLD_CYCLES     = 60;
  localparam int HOLD_AT_FIRST   = 300;
  localparam int HOLD_AT_SECOND  = 700;
  localparam int DRAIN_CYCLES    = 10;
  localparam int MAX_PRINTS      = 100;

  // Drift bookkeeping at the default crystal and tolerance
  localparam int unsigned DRIFT_TICKS = MICROS_PER_SECOND / (CRYSTAL_HZ_DEFAULT / 2);

  // One result transaction
  typedef struct packed {
    logic [HOUR_W-1:0]    hour;
    logic [MINUTE_W-1:0]  minute;
    logic [SECOND_W-1:0]  second;
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
    logic [WEEKDAY_W-1:0] weekday;
    logic                 summer_time;
    logic [LEVEL_W-1:0]   drift_level;
    logic                 minute_marker;
    logic                 second_phase;
  } clock_reading_t;

  // Item waiting to be offered; steady items are sent without idling
  typedef struct {
    sync_t item;
    bit    steady;
  } pending_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sync_t bus_item  = '0;
  logic  in_valid  = 1'b0;
  logic  out_ready = 1'b0;
  bit    calm      = 1'b0;
  int    hold_left = 0;

  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [HOUR_W-1:0]    hour_o;
  logic [MINUTE_W-1:0]  minute_o;
  logic [SECOND_W-1:0]  second_o;
  logic [DAY_W-1:0]     day_o;
  logic [MONTH_W-1:0]   month_o;
  logic [YEAR_W-1:0]    year_o;
  logic [WEEKDAY_W-1:0] weekday_o;
  logic                 summer_time_o;
  logic [LEVEL_W-1:0]   drift_level_o;
  logic                 minute_marker_o;
  logic                 second_phase_o;

  pending_t       offer_queue[$];
  clock_reading_t expected_readings[$];

  int queued_items    = 0;
  int accepted_items  = 0;
  int ticks_sent      = 0;
  int syncs_sent      = 0;
  int results_seen    = 0;
  int rollovers_seen  = 0;
  int top_drift_level = 0;
  int mismatch_count  = 0;

  // Predicted calendar state
  logic [HOUR_W-1:0]    cal_hour;
  logic [MINUTE_W-1:0]  cal_minute;
  logic [SECOND_W-1:0]  cal_second;
  logic [DAY_W-1:0]     cal_day;
  logic [MONTH_W-1:0]   cal_month;
  logic [YEAR_W-1:0]    cal_year;
  logic [WEEKDAY_W-1:0] cal_weekday;
  logic                 cal_dst;
  logic                 cal_leap;
  logic [DAY_W-1:0]     cal_month_len;
  logic [SECOND_W-1:0]  cal_minute_len;
  logic                 cal_half;
  int unsigned          drift_ticks;
  int unsigned          drift_acc;

  radio_synced_calendar_clock_top dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready_o),
    .func_i               (bus_item.func),
    .sync_year_i          (bus_item.year),
    .sync_month_i         (bus_item.month),
    .sync_day_i           (bus_item.day),
    .sync_weekday_i       (bus_item.weekday),
    .sync_hour_i          (bus_item.hour),
    .sync_minute_i        (bus_item.minute),
    .sync_second_i        (bus_item.second),
    .sync_minute_length_i (bus_item.minute_length),
    .sync_summer_time_i   (bus_item.summer_time),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready),
    .hour_o               (hour_o),
    .minute_o             (minute_o),
    .second_o             (second_o),
    .day_o                (day_o),
    .month_o              (month_o),
    .year_o               (year_o),
    .weekday_o            (weekday_o),
    .summer_time_o        (summer_time_o),
    .drift_level_o        (drift_level_o),
    .minute_marker_o      (minute_marker_o),
    .second_phase_o       (second_phase_o)
  );

  always #10 clk_i = ~clk_i;

  // Gregorian leap rule
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    int unsigned yr;
    yr = y;
    return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
  endfunction

  // Days in a month; codes past December count as 31
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m, input logic leap);
    case (m)
      MONTH_FEB: return leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  function automatic void reset_clock();
    cal_hour       = '0;
    cal_minute     = '0;
    cal_second     = '0;
    cal_day        = '0;
    cal_month      = MONTH_JAN;
    cal_year       = YEAR_RESET;
    cal_weekday    = '0;
    cal_dst        = 1'b0;
    cal_leap       = 1'b1;
    cal_month_len  = 5'd31;
    cal_minute_len = MINUTE_LEN_STD;
    cal_half       = 1'b0;
    drift_ticks    = 0;
    drift_acc      = 0;
  endfunction

  // Carry a finished minute through hour, day, month, year and weekday
  function automatic void roll_minute();
    if (32'(cal_minute) + 1 < 32'(MINUTES_PER_HOUR)) begin
      cal_minute = cal_minute + 1'b1;
      return;
    end
    cal_minute = '0;
    if (32'(cal_hour) + 1 < 32'(HOURS_PER_DAY)) begin
      cal_hour = cal_hour + 1'b1;
      return;
    end
    cal_hour = '0;
    if (32'(cal_day) + 1 >= 32'(cal_month_len)) begin
      cal_day = '0;
      if (32'(cal_month) + 1 >= 32'(MONTHS_PER_YEAR)) begin
        cal_month = MONTH_JAN;
        cal_year  = cal_year + 1'b1;
        cal_leap  = is_leap(cal_year);
      end else begin
        cal_month = cal_month + 1'b1;
      end
      cal_month_len = days_in(cal_month, cal_leap);
    end else begin
      cal_day = cal_day + 1'b1;
    end
    if (32'(cal_weekday) + 1 >= 32'(DAYS_PER_WEEK)) begin
      cal_weekday = '0;
    end else begin
      cal_weekday = cal_weekday + 1'b1;
    end
  endfunction

  function automatic logic [LEVEL_W-1:0] drift_grade();
    if (drift_acc >= CRYSTAL_HZ_DEFAULT) return DRIFT_LVL_1S;
    if (drift_acc >= CRYSTAL_HZ_DEFAULT / 10) return DRIFT_LVL_100MS;
    if (drift_acc >= CRYSTAL_HZ_DEFAULT / 20) return DRIFT_LVL_50MS;
    if (drift_acc >= CRYSTAL_HZ_DEFAULT / 100) return DRIFT_LVL_10MS;
    return DRIFT_LVL_FINE;
  endfunction

  // Apply one accepted transaction to the predicted clock and return its reading
  function automatic clock_reading_t advance_clock(input sync_t it);
    clock_reading_t r;
    logic rolled;
    logic stepped;
    rolled  = 1'b0;
    stepped = 1'b0;
    if (it.func == FUNC_SYNC) begin
      cal_year       = it.year;
      cal_month      = it.month;
      cal_day        = it.day;
      cal_weekday    = it.weekday;
      cal_hour       = it.hour;
      cal_minute     = it.minute;
      cal_second     = it.second;
      cal_minute_len = it.minute_length;
      cal_dst        = it.summer_time;
      cal_leap       = is_leap(it.year);
      cal_month_len  = days_in(it.month, cal_leap);
      cal_half       = 1'b0;
      drift_ticks    = 0;
      drift_acc      = 0;
    end else begin
      drift_ticks = drift_ticks + 1;
      if (drift_ticks >= DRIFT_TICKS) begin
        drift_ticks = 0;
        drift_acc   = drift_acc + TOLERANCE_PPM_DEFAULT;
        if (drift_acc > DRIFT_MAX) drift_acc = DRIFT_MAX;
      end
      if (cal_half) begin
        cal_half = 1'b0;
      end else begin
        cal_half = 1'b1;
        stepped  = 1'b1;
        if (32'(cal_second) + 1 >= 32'(cal_minute_len)) begin
          cal_second     = '0;
          cal_minute_len = MINUTE_LEN_STD;
          rolled         = 1'b1;
          roll_minute();
        end else begin
          cal_second = cal_second + 1'b1;
        end
      end
    end
    r.hour          = cal_hour;
    r.minute        = cal_minute;
    r.second        = cal_second;
    r.day           = cal_day;
    r.month         = cal_month;
    r.year          = cal_year;
    r.weekday       = cal_weekday;
    r.summer_time   = cal_dst;
    r.drift_level   = drift_grade();
    r.minute_marker = rolled;
    r.second_phase  = stepped;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got_v, input int want_v);
    if (got_v != want_v) begin
      report_mismatch($sformatf("%s: got %0d, expected %0d (result %0d)",
                                name, got_v, want_v, results_seen));
    end
  endtask

  task automatic compare_reading(input clock_reading_t got, input clock_reading_t want);
    check_field("hour", got.hour, want.hour);
    check_field("minute", got.minute, want.minute);
    check_field("second", got.second, want.second);
    check_field("day", got.day, want.day);
    check_field("month", got.month, want.month);
    check_field("year", got.year, want.year);
    check_field("weekday", got.weekday, want.weekday);
    check_field("summer_time", got.summer_time, want.summer_time);
    check_field("drift_level", got.drift_level, want.drift_level);
    check_field("minute_marker", got.minute_marker, want.minute_marker);
    check_field("second_phase", got.second_phase, want.second_phase);
  endtask

  // Stimulus helpers
  function automatic sync_t random_item(input logic f);
    logic [63:0] raw;
    sync_t it;
    raw = {$urandom, $urandom};
    it = raw[$bits(sync_t)-1:0];
    it.func = f;
    return it;
  endfunction

  function automatic sync_t make_sync(input int y, input int mo, input int d, input int wd,
                                      input int h, input int mi, input int s,
                                      input int len, input int dst);
    sync_t it;
    it.func          = FUNC_SYNC;
    it.year          = YEAR_W'(y);
    it.month         = MONTH_W'(mo);
    it.day           = DAY_W'(d);
    it.weekday       = WEEKDAY_W'(wd);
    it.hour          = HOUR_W'(h);
    it.minute        = MINUTE_W'(mi);
    it.second        = SECOND_W'(s);
    it.minute_length = SECOND_W'(len);
    it.summer_time   = dst[0];
    return it;
  endfunction

  // Sync biased towards the end of a minute, day, month and year
  function automatic sync_t random_sync();
    int y;
    int mo;
    int d;
    int len;
    int s;
    int month_days;
    case ($urandom_range(0, 3))
      0: y = $urandom_range(0, 9999);
      1: y = 100 * $urandom_range(0, 99);
      2: y = 400 * $urandom_range(0, 24);
      default: y = 9999;
    endcase
    mo = ($urandom_range(0, 3) == 0) ? int'(MONTH_DEC) : $urandom_range(0, 11);
    month_days = days_in(MONTH_W'(mo), is_leap(YEAR_W'(y)));
    d = $urandom_range(0, 1) ? month_days - 1 : $urandom_range(0, month_days - 1);
    len = $urandom_range(59, 61);
    s = $urandom_range(0, 1) ? len - 1 - $urandom_range(0, 1) : $urandom_range(0, 60);
    return make_sync(y, mo, d, $urandom_range(0, 6),
                     $urandom_range(0, 1) ? 23 : $urandom_range(0, 23),
                     $urandom_range(0, 1) ? 59 : $urandom_range(0, 59),
                     s, len, $urandom_range(0, 1));
  endfunction

  task automatic offer(input sync_t it, input bit steady);
    pending_t p;
    p.item   = it;
    p.steady = steady;
    offer_queue.push_back(p);
    queued_items++;
  endtask

  task automatic queue_ticks(input int n, input bit steady);
    repeat (n) offer(random_item(FUNC_TICK), steady);
  endtask

  // Sender: offer queued transactions, predict each one as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    pending_t head;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      bus_item <= '0;
      calm     <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_readings.push_back(advance_clock(bus_item));
        accepted_items++;
        if (bus_item.func == FUNC_SYNC) syncs_sent++;
        else ticks_sent++;
      end
      if (!in_valid || in_ready_o) begin
        if (offer_queue.size() != 0 &&
            (offer_queue[0].steady || hold_left != 0 || $urandom_range(0, 99) >= IDLE_PCT)) begin
          head = offer_queue.pop_front();
          bus_item <= head.item;
          calm     <= head.steady;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result against the oldest prediction, stall at random
  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    clock_reading_t got;
    clock_reading_t want;
    bit start_hold;
    start_hold = 1'b0;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        got = '{hour_o, minute_o, second_o, day_o, month_o, year_o, weekday_o,
                summer_time_o, drift_level_o, minute_marker_o, second_phase_o};
        results_seen++;
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_readings.pop_front();
          compare_reading(got, want);
          rollovers_seen += want.minute_marker;
          if (int'(want.drift_level) > top_drift_level) top_drift_level = want.drift_level;
        end
        start_hold = (results_seen == HOLD_AT_FIRST) || (results_seen == HOLD_AT_SECOND);
      end
      // Hold off long enough for the block to fill and stall its input
      if (start_hold) begin
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Build the stimulus, release reset and wait for every result
  initial begin : main_proc
    int directed_end;
    int pick;
    reset_clock();

    // Plain ticks from the reset date
    queue_ticks(3, 1'b0);
    // Year wraps past 16383 at the turn of the year
    offer(make_sync(16383, MONTH_DEC, 30, 6, 23, 59, 59, 60, 1), 1'b0);
    queue_ticks(2, 1'b0);
    // Leap second at the end of February in a non-leap century year
    offer(make_sync(2100, MONTH_FEB, 27, 3, 23, 59, 59, 61, 0), 1'b0);
    queue_ticks(4, 1'b0);
    // Short minute from February 29th into March of a leap century year
    offer(make_sync(2000, MONTH_FEB, 28, 2, 23, 59, 58, 59, 0), 1'b0);
    queue_ticks(2, 1'b0);
    // Month code out of range reads as 31 days
    offer(make_sync(9999, 15, 30, 6, 23, 59, 59, 60, 1), 1'b0);
    queue_ticks(2, 1'b0);
    // Every counter but the year beyond its range, and a zero minute length
    offer(make_sync(16383, 12, 31, 7, 31, 63, 63, 0, 0), 1'b0);
    queue_ticks(2, 1'b0);
    // Second already past the minute length
    offer(make_sync(0, MONTH_JAN, 0, 0, 0, 0, 60, 59, 0), 1'b0);
    queue_ticks(1, 1'b0);
    directed_end = queued_items;

    // Mostly sync-then-ticks sequences, with noise and broken sequences
    while (queued_items < directed_end + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        offer(random_sync(), 1'b0);
        queue_ticks($urandom_range(2, 40), 1'b0);
      end else if (pick == 8) begin
        offer(random_item(FUNC_SYNC), 1'b0);
        queue_ticks($urandom_range(0, 4), 1'b0);
      end else if ($urandom_range(0, 1) != 0) begin
        queue_ticks($urandom_range(120, 250), 1'b0);
      end else begin
        offer(random_sync(), 1'b0);
        offer(random_sync(), 1'b0);
      end
    end

    // Long unsynchronised run across several drift periods; the first CALM_TICKS ticks go back to back
    offer(make_sync(9999, MONTH_DEC, 30, 5, 23, 50, 0, 60, 0), 1'b1);
    queue_ticks(CALM_TICKS, 1'b1);
    queue_ticks(DRIFT_RUN_TICKS - CALM_TICKS, 1'b0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_items != queued_items || expected_readings.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results from %0d ticks and %0d syncs.",
             results_seen, ticks_sent, syncs_sent);
    $display("Saw %0d minute rollovers; drift level reached %0d.",
             rollovers_seen, top_drift_level);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timed out with %0d results still expected", expected_readings.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
